@@ rtl/fac_pkg.sv @@
// Package for the first-fit segment allocator: sizes, codes, token and
// segment types shared by the cell, chain and top level. No dependencies.
`default_nettype none
package fac_pkg;

  localparam int BUF_BYTES    = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_SEGMENTS = 256;

  localparam int SZ_W   = $clog2(BUF_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int REQ_W  = 17;
  localparam int CALC_W = REQ_W + 1;

  typedef enum logic [1:0] {
    K_ATTACH = 2'd0,
    K_ALLOC  = 2'd1,
    K_FREE   = 2'd2,
    K_DETACH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_ATTACHED = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  // token modes traveling down a chain
  typedef enum logic [2:0] {
    M_IDLE, // no token
    M_SRCH, // first-fit search
    M_FIND, // search by offset
    M_INS,  // sorted insert, looking for place
    M_INSR, // insert carried segment, ripple right
    M_REPL, // overwrite this cell, then done
    M_SHL,  // remove: take right neighbor
    M_PASS  // done, carry payload to the end
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_F_WAIT,
    S_A_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [SZ_W-1:0] off;
    logic [SZ_W-1:0] size;
  } seg_t;

  typedef struct packed {
    mode_t mode;
    seg_t  seg;
  } tok_t;

  typedef struct packed {
    logic [CALC_W-1:0] req;
    logic              split_ok;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/fac_if.sv @@
// Valid/ready channel interfaces for allocator items and results.
// Depends on nothing.
`default_nettype none
interface fac_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [16:0] req_bytes;
  logic [15:0] seg_offset;
  logic [31:0] base_address;

  modport source (output valid, kind, req_bytes, seg_offset, base_address, input ready);
  modport sink (input valid, kind, req_bytes, seg_offset, base_address, output ready);
endinterface

interface fac_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_offset;
  logic [16:0] detached_length;
  logic [31:0] detached_base;

  modport source (output valid, status, granted_offset, detached_length, detached_base,
                  input ready);
  modport sink (input valid, status, granted_offset, detached_length, detached_base,
                output ready);
endinterface
`default_nettype wire

@@ rtl/first_fit_segment_allocator_core.sv @@
// Top level of the first-fit segment allocator: control sequencer and the
// free and active segment tables. Depends on fac_pkg, fac_if, fac_chain.
//
// One item is handled at a time. Detach, a zero-length or refused attach and
// an alloc refused for a full active table go straight to the result. Attach
// of a buffer, an alloc with no fit and a bad free each send one token down
// one table. A granted alloc and a good free send a token down both tables
// in turn. The result is held until taken, and the next item is taken after
// that.
`default_nettype none
module first_fit_segment_allocator_core (
  input  logic         clk,
  input  logic         rst,
  fac_item_if.sink     item,
  fac_result_if.source result
);

  fac_pkg::state_t state, state_next;
  fac_pkg::kind_t  kind_q, kind_next;
  logic [fac_pkg::CNT_W-1:0] fcount, fcount_next, acount, acount_next;
  logic [16:0] alen, alen_next;
  logic [31:0] abase, abase_next;
  logic [fac_pkg::REQ_W-1:0] req_q, req_next;
  fac_pkg::status_t status_q, status_next;
  logic [15:0] granted_q, granted_next;
  logic [16:0] dlen_q, dlen_next;
  logic [31:0] dbase_q, dbase_next;

  fac_pkg::tok_t f_launch, a_launch, f_tail, a_tail;
  fac_pkg::seg_t f_head, a_head_unused;
  fac_pkg::ctl_t ctl;
  logic [fac_pkg::SZ_W-1:0] managed, s_end;
  logic accept;

  assign accept = item.valid && item.ready;
  assign item.ready = (state == fac_pkg::S_IDLE);
  assign result.valid = (state == fac_pkg::S_OUT);
  assign result.status = status_q;
  assign result.granted_offset = granted_q;
  assign result.detached_length = dlen_q;
  assign result.detached_base = dbase_q;

  // cell 0 sees the token in the accept cycle, before req_q is loaded
  assign ctl = '{
    req: fac_pkg::CALC_W'((state == fac_pkg::S_IDLE) ? item.req_bytes : req_q),
    split_ok: ({1'b0, fcount} + {1'b0, acount}) <
              (fac_pkg::CNT_W+1)'(fac_pkg::MAX_SEGMENTS)
  };

  assign managed = (fac_pkg::SZ_W'(item.req_bytes) < fac_pkg::SZ_W'(fac_pkg::BUF_BYTES)) ?
                   fac_pkg::SZ_W'(item.req_bytes) : fac_pkg::SZ_W'(fac_pkg::BUF_BYTES);
  assign s_end = a_tail.seg.off + a_tail.seg.size;

  fac_chain u_free (
    .clk(clk), .rst(rst), .tok_in(f_launch), .ctl(ctl), .count(fcount),
    .tok_out(f_tail), .head_seg(f_head)
  );

  fac_chain u_active (
    .clk(clk), .rst(rst), .tok_in(a_launch), .ctl(ctl), .count(acount),
    .tok_out(a_tail), .head_seg(a_head_unused)
  );

  always_comb begin
    state_next  = state;
    kind_next   = kind_q;
    fcount_next = fcount;
    acount_next = acount;
    alen_next   = alen;
    abase_next  = abase;
    req_next    = req_q;
    status_next = status_q;
    granted_next = granted_q;
    dlen_next   = dlen_q;
    dbase_next  = dbase_q;
    f_launch = '{mode: fac_pkg::M_IDLE, seg: '0};
    a_launch = '{mode: fac_pkg::M_IDLE, seg: '0};
    unique case (state)
      fac_pkg::S_IDLE: begin
        if (accept) begin
          kind_next    = fac_pkg::kind_t'(item.kind);
          req_next     = item.req_bytes;
          status_next  = fac_pkg::ST_OK;
          granted_next = '0;
          dlen_next    = '0;
          dbase_next   = '0;
          unique case (fac_pkg::kind_t'(item.kind))
            fac_pkg::K_ATTACH: begin
              if (alen != '0) begin
                status_next = fac_pkg::ST_ATTACHED;
                state_next  = fac_pkg::S_OUT;
              end else begin
                alen_next   = item.req_bytes;
                abase_next  = item.base_address;
                fcount_next = '0;
                acount_next = '0;
                if (managed != '0) begin
                  f_launch.mode     = fac_pkg::M_INSR;
                  f_launch.seg.off  = '0;
                  f_launch.seg.size = managed;
                  state_next = fac_pkg::S_F_WAIT;
                end else begin
                  state_next = fac_pkg::S_OUT;
                end
              end
            end
            fac_pkg::K_ALLOC: begin
              if (acount >= fac_pkg::CNT_W'(fac_pkg::MAX_SEGMENTS)) begin
                status_next = fac_pkg::ST_NO_SPACE;
                state_next  = fac_pkg::S_OUT;
              end else begin
                f_launch.mode = fac_pkg::M_SRCH;
                state_next = fac_pkg::S_F_WAIT;
              end
            end
            fac_pkg::K_FREE: begin
              a_launch.mode    = fac_pkg::M_FIND;
              a_launch.seg.off = fac_pkg::SZ_W'(item.seg_offset);
              state_next = fac_pkg::S_A_WAIT;
            end
            fac_pkg::K_DETACH: begin
              dlen_next   = alen;
              dbase_next  = abase;
              alen_next   = '0;
              abase_next  = '0;
              fcount_next = '0;
              acount_next = '0;
              state_next  = fac_pkg::S_OUT;
            end
          endcase
        end
      end
      fac_pkg::S_F_WAIT: begin
        if (f_tail.mode != fac_pkg::M_IDLE) begin
          priority case (kind_q)
            fac_pkg::K_ATTACH: begin
              fcount_next = fac_pkg::CNT_W'(1);
              state_next  = fac_pkg::S_OUT;
            end
            fac_pkg::K_ALLOC: begin
              if (f_tail.mode == fac_pkg::M_SRCH) begin
                status_next = fac_pkg::ST_NO_SPACE;
                state_next  = fac_pkg::S_OUT;
              end else begin
                if (f_tail.mode == fac_pkg::M_SHL) fcount_next = fcount - 1'b1;
                granted_next  = f_tail.seg.off[15:0];
                a_launch.mode = fac_pkg::M_INSR;
                a_launch.seg  = f_tail.seg;
                state_next    = fac_pkg::S_A_WAIT;
              end
            end
            default: begin
              // free: count follows how the returned segment was merged
              if (f_tail.mode == fac_pkg::M_SHL) fcount_next = fcount - 1'b1;
              else if (f_tail.mode == fac_pkg::M_INSR) fcount_next = fcount + 1'b1;
              state_next = fac_pkg::S_OUT;
            end
          endcase
        end
      end
      fac_pkg::S_A_WAIT: begin
        if (a_tail.mode != fac_pkg::M_IDLE) begin
          if (kind_q == fac_pkg::K_ALLOC) begin
            acount_next = acount + 1'b1;
            state_next  = fac_pkg::S_OUT;
          end else if (a_tail.mode == fac_pkg::M_FIND) begin
            status_next = fac_pkg::ST_BAD_FREE;
            state_next  = fac_pkg::S_OUT;
          end else begin
            acount_next = acount - 1'b1;
            state_next  = fac_pkg::S_F_WAIT;
            f_launch.seg = a_tail.seg;
            // decide for the position in front of the first cell
            if (fcount == '0 || f_head.off > a_tail.seg.off) begin
              if (fcount != '0 && s_end == f_head.off) begin
                f_launch.mode     = fac_pkg::M_REPL;
                f_launch.seg.size = a_tail.seg.size + f_head.size;
              end else begin
                f_launch.mode = fac_pkg::M_INSR;
              end
            end else begin
              f_launch.mode = fac_pkg::M_INS;
            end
          end
        end
      end
      fac_pkg::S_OUT: begin
        if (result.ready) state_next = fac_pkg::S_IDLE;
      end
      default: state_next = fac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fac_pkg::S_IDLE;
      fcount <= '0;
      acount <= '0;
      alen   <= '0;
      abase  <= '0;
    end else begin
      state  <= state_next;
      fcount <= fcount_next;
      acount <= acount_next;
      alen   <= alen_next;
      abase  <= abase_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q    <= kind_next;
    req_q     <= req_next;
    status_q  <= status_next;
    granted_q <= granted_next;
    dlen_q    <= dlen_next;
    dbase_q   <= dbase_next;
  end

`ifndef ASSERT_OFF
  a_seg_total: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, fcount} + {1'b0, acount}) <= (fac_pkg::CNT_W+1)'(fac_pkg::MAX_SEGMENTS))
    else $error("free plus active segments exceed table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != fac_pkg::S_IDLE))
    else $error("accepted transaction left no work");

  a_detach_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.kind == fac_pkg::K_DETACH) |=> (fcount == '0 && acount == '0
      && alen == '0))
    else $error("detach left state behind");

  a_tail_idle: assert property (@(posedge clk) disable iff (rst)
    (state == fac_pkg::S_IDLE || state == fac_pkg::S_OUT) |->
      (f_tail.mode == fac_pkg::M_IDLE && a_tail.mode == fac_pkg::M_IDLE))
    else $error("token left a table while no wave was pending");
`endif

endmodule
`default_nettype wire

@@ rtl/fac_cell.sv @@
// One table cell: holds a segment and the token register that passes to
// the next cell. Depends on fac_pkg.
`default_nettype none
module fac_cell (
  input  logic          clk,
  input  logic          rst,
  input  fac_pkg::tok_t tok_in,
  input  fac_pkg::ctl_t ctl,
  input  logic          valid,
  input  logic          nxt_valid,
  input  fac_pkg::seg_t nxt_seg,
  output fac_pkg::seg_t seg,
  output fac_pkg::tok_t tok_out
);

  fac_pkg::seg_t seg_next;
  fac_pkg::tok_t tok_next;
  logic [fac_pkg::CALC_W-1:0] sz;
  logic [fac_pkg::SZ_W-1:0]   my_end;
  logic [fac_pkg::SZ_W-1:0]   s_end;
  logic pos, l_hit, r_hit;

  always_comb begin
    seg_next = seg;
    tok_next = tok_in;
    sz     = fac_pkg::CALC_W'(seg.size);
    my_end = seg.off + seg.size;
    s_end  = tok_in.seg.off + tok_in.seg.size;
    pos    = !nxt_valid || (nxt_seg.off > tok_in.seg.off);
    l_hit  = (my_end == tok_in.seg.off);
    r_hit  = nxt_valid && (s_end == nxt_seg.off);
    unique case (tok_in.mode)
      fac_pkg::M_SRCH: begin
        if (valid && sz >= fac_pkg::CALC_W'(fac_pkg::HEADER_BYTES) &&
            sz - fac_pkg::CALC_W'(fac_pkg::HEADER_BYTES) >= ctl.req) begin
          if (ctl.split_ok &&
              sz >= fac_pkg::CALC_W'(2 * fac_pkg::HEADER_BYTES) + ctl.req) begin
            seg_next.off  = fac_pkg::SZ_W'(fac_pkg::CALC_W'(seg.off) +
                            fac_pkg::CALC_W'(fac_pkg::HEADER_BYTES) + ctl.req);
            seg_next.size = fac_pkg::SZ_W'(sz - fac_pkg::CALC_W'(fac_pkg::HEADER_BYTES)
                            - ctl.req);
            tok_next.mode = fac_pkg::M_PASS;
            tok_next.seg.off  = seg.off;
            tok_next.seg.size = fac_pkg::SZ_W'(fac_pkg::CALC_W'(fac_pkg::HEADER_BYTES)
                                + ctl.req);
          end else begin
            seg_next = nxt_seg;
            tok_next.mode = fac_pkg::M_SHL;
            tok_next.seg  = seg;
          end
        end
      end
      fac_pkg::M_FIND: begin
        if (valid && seg.off == tok_in.seg.off) begin
          seg_next = nxt_seg;
          tok_next.mode = fac_pkg::M_SHL;
          tok_next.seg  = seg;
        end
      end
      fac_pkg::M_SHL: seg_next = nxt_seg;
      fac_pkg::M_INSR: begin
        seg_next = tok_in.seg;
        tok_next.seg = seg;
      end
      fac_pkg::M_REPL: begin
        seg_next = tok_in.seg;
        tok_next.mode = fac_pkg::M_PASS;
      end
      fac_pkg::M_INS: begin
        // arriving here means this cell lies below the returned segment
        if (pos) begin
          if (l_hit && r_hit) begin
            seg_next.size = seg.size + tok_in.seg.size + nxt_seg.size;
            tok_next.mode = fac_pkg::M_SHL;
          end else if (l_hit) begin
            seg_next.size = seg.size + tok_in.seg.size;
            tok_next.mode = fac_pkg::M_PASS;
          end else if (r_hit) begin
            tok_next.mode = fac_pkg::M_REPL;
            tok_next.seg.size = tok_in.seg.size + nxt_seg.size;
          end else begin
            tok_next.mode = fac_pkg::M_INSR;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
    if (rst) begin
      tok_out.mode <= fac_pkg::M_IDLE;
      tok_out.seg  <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fac_chain.sv @@
// Row of MAX_SEGMENTS cells forming one segment table; a token enters at
// cell 0 and leaves after the last cell. Depends on fac_pkg, fac_cell.
`default_nettype none
module fac_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  fac_pkg::tok_t              tok_in,
  input  fac_pkg::ctl_t              ctl,
  input  logic [fac_pkg::CNT_W-1:0]  count,
  output fac_pkg::tok_t              tok_out,
  output fac_pkg::seg_t              head_seg
);

  fac_pkg::seg_t segs [fac_pkg::MAX_SEGMENTS];
  fac_pkg::tok_t toks [fac_pkg::MAX_SEGMENTS+1];

  assign toks[0]  = tok_in;
  assign tok_out  = toks[fac_pkg::MAX_SEGMENTS];
  assign head_seg = segs[0];

  for (genvar i = 0; i < fac_pkg::MAX_SEGMENTS; i++) begin : g_cell
    fac_pkg::seg_t nxt;
    if (i == fac_pkg::MAX_SEGMENTS - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = segs[i+1];
    end
    fac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (toks[i]),
      .ctl       (ctl),
      .valid     (fac_pkg::CNT_W'(i) < count),
      .nxt_valid (fac_pkg::CNT_W'(i + 1) < count),
      .nxt_seg   (nxt),
      .seg       (segs[i]),
      .tok_out   (toks[i+1])
    );
  end

endmodule
`default_nettype wire

@@ tb/sv/first_fit_segment_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_segment_allocator_core: directed table,
// then random attach/alloc/free/detach traffic. Depends on fac_pkg, fac_if and the core.
module first_fit_segment_allocator_core_tb;
  import fac_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] granted;
    logic [16:0] dlen;
    logic [31:0] dbase;
  } seg_result_t;

  typedef struct {
    kind_t       kind;
    logic [16:0] req;
    logic [15:0] off;
    logic [31:0] base;
    bit          typed;
    seg_result_t exp;
  } dir_row_t;

  localparam int N_RANDOM = 1730;
  localparam int CALM_AT  = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  fac_item_if   item ();
  fac_result_if result ();

  first_fit_segment_allocator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  // shadow allocator state
  int unsigned fr_off [MAX_SEGMENTS];
  int unsigned fr_sz  [MAX_SEGMENTS];
  int unsigned ac_off [MAX_SEGMENTS];
  int unsigned ac_sz  [MAX_SEGMENTS];
  int unsigned fr_cnt, ac_cnt, att_len, att_base;

  seg_result_t pending_results[$];
  dir_row_t    rows[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  bit          calm = 1'b0;

  function automatic void free_drop(int unsigned i);
    for (int unsigned j = i; j + 1 < fr_cnt; j++) begin
      fr_off[j] = fr_off[j+1];
      fr_sz[j]  = fr_sz[j+1];
    end
    fr_cnt--;
  endfunction

  function automatic status_t alloc_first_fit(int unsigned req, output int unsigned granted);
    int unsigned i;
    int unsigned g_off, g_sz;
    granted = 0;
    for (i = 0; i < fr_cnt; i++)
      if (fr_sz[i] >= HEADER_BYTES && fr_sz[i] - HEADER_BYTES >= req) break;
    if (i >= fr_cnt || ac_cnt >= MAX_SEGMENTS) return ST_NO_SPACE;
    g_off = fr_off[i];
    g_sz  = fr_sz[i];
    if (g_sz >= 2 * HEADER_BYTES + req && fr_cnt + ac_cnt < MAX_SEGMENTS) begin
      fr_off[i] = g_off + HEADER_BYTES + req;
      fr_sz[i]  = g_sz - HEADER_BYTES - req;
      g_sz      = HEADER_BYTES + req;
    end else begin
      free_drop(i);
    end
    ac_off[ac_cnt] = g_off;
    ac_sz[ac_cnt]  = g_sz;
    ac_cnt++;
    granted = g_off;
    return ST_OK;
  endfunction

  function automatic status_t release_segment(int unsigned off);
    int unsigned i, p;
    int unsigned s_off, s_sz;
    for (i = 0; i < ac_cnt; i++)
      if (ac_off[i] == off) break;
    if (i >= ac_cnt) return ST_BAD_FREE;
    s_off = ac_off[i];
    s_sz  = ac_sz[i];
    ac_off[i] = ac_off[ac_cnt-1];
    ac_sz[i]  = ac_sz[ac_cnt-1];
    ac_cnt--;
    for (p = 0; p < fr_cnt; p++)
      if (fr_off[p] > s_off) break;
    for (int unsigned j = fr_cnt; j > p; j--) begin
      fr_off[j] = fr_off[j-1];
      fr_sz[j]  = fr_sz[j-1];
    end
    fr_off[p] = s_off;
    fr_sz[p]  = s_sz;
    fr_cnt++;
    if (p + 1 < fr_cnt && fr_off[p] + fr_sz[p] == fr_off[p+1]) begin
      fr_sz[p] += fr_sz[p+1];
      free_drop(p + 1);
    end
    if (p > 0 && fr_off[p-1] + fr_sz[p-1] == fr_off[p]) begin
      fr_sz[p-1] += fr_sz[p];
      free_drop(p);
    end
    return ST_OK;
  endfunction

  function automatic seg_result_t plan_item(kind_t kind, logic [16:0] req, logic [15:0] off,
                                            logic [31:0] base);
    seg_result_t r;
    int unsigned g;
    r = '{ST_OK, 16'd0, 17'd0, 32'd0};
    case (kind)
      K_ATTACH: begin
        if (att_len != 0) begin
          r.status = ST_ATTACHED;
        end else begin
          att_len  = req;
          att_base = base;
          ac_cnt   = 0;
          fr_cnt   = 0;
          if (req != 0) begin
            fr_off[0] = 0;
            fr_sz[0]  = (req < BUF_BYTES) ? req : BUF_BYTES;
            fr_cnt    = 1;
          end
        end
      end
      K_ALLOC: begin
        r.status = alloc_first_fit(req, g);
        r.granted = g[15:0];
      end
      K_FREE: r.status = release_segment(off);
      default: begin
        r.dlen   = att_len[16:0];
        r.dbase  = att_base;
        att_len  = 0;
        att_base = 0;
        fr_cnt   = 0;
        ac_cnt   = 0;
      end
    endcase
    return r;
  endfunction

  task automatic add_row(kind_t k, int unsigned req, int unsigned off, logic [31:0] base,
                         bit typed, status_t st, int unsigned dlen, logic [31:0] dbase);
    dir_row_t d;
    d.kind = k; d.req = req[16:0]; d.off = off[15:0]; d.base = base; d.typed = typed;
    d.exp = '{st, 16'd0, dlen[16:0], dbase};
    rows.push_back(d);
  endtask

  // drive one transaction and book its expected result on acceptance
  task automatic send(kind_t k, logic [16:0] req, logic [15:0] off, logic [31:0] base,
                      bit typed, seg_result_t exp);
    seg_result_t p;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.kind         <= k;
    item.req_bytes    <= req;
    item.seg_offset   <= off;
    item.base_address <= base;
    do @(posedge clk); while (!item.ready);
    p = plan_item(k, req, off, base);
    if (typed) pending_results.push_back(exp);
    else pending_results.push_back(p);
    items_sent++;
    if (items_sent >= CALM_AT) calm = 1'b1;
  endtask

  initial begin
    seg_result_t none;
    kind_t       k;
    logic [16:0] req;
    logic [15:0] off;
    logic [31:0] base;
    int          pick;
    none = '{ST_OK, 16'd0, 17'd0, 32'd0};
    item.valid = 1'b0; item.kind = K_ATTACH; item.req_bytes = '0;
    item.seg_offset = '0; item.base_address = '0;
    fr_cnt = 0; ac_cnt = 0; att_len = 0; att_base = 0;

    add_row(K_DETACH, 0, 0, 0, 1, ST_OK, 0, 0);
    add_row(K_ALLOC, 0, 0, 0, 1, ST_NO_SPACE, 0, 0);
    add_row(K_FREE, 0, 0, 0, 1, ST_BAD_FREE, 0, 0);
    add_row(K_ATTACH, 0, 0, 32'hFFFF_FFFF, 1, ST_OK, 0, 0);     // zero-length attach
    add_row(K_ALLOC, 0, 0, 0, 1, ST_NO_SPACE, 0, 0);
    add_row(K_ATTACH, 65536, 16'hFFFF, 0, 1, ST_OK, 0, 0);
    add_row(K_ATTACH, 100, 0, 32'h1234_5678, 1, ST_ATTACHED, 0, 0);
    add_row(K_ALLOC, 0, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_ALLOC, 17'h1FFFF, 0, 0, 1, ST_NO_SPACE, 0, 0);
    add_row(K_FREE, 5, 5, 0, 1, ST_BAD_FREE, 0, 0);
    add_row(K_FREE, 0, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_ALLOC, 65520, 0, 0, 0, ST_OK, 0, 0);               // whole buffer, no split
    add_row(K_ALLOC, 0, 0, 0, 1, ST_NO_SPACE, 0, 0);
    add_row(K_DETACH, 0, 0, 0, 1, ST_OK, 65536, 0);
    add_row(K_ATTACH, 17'h1FFFF, 0, 32'hA5A5_A5A5, 1, ST_OK, 0, 0); // oversized
    add_row(K_ALLOC, 8, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_ALLOC, 8, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_FREE, 0, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_FREE, 24, 24, 0, 0, ST_OK, 0, 0);                  // merge both sides
    add_row(K_DETACH, 0, 0, 0, 1, ST_OK, 17'h1FFFF, 32'hA5A5_A5A5);
    add_row(K_ATTACH, 10, 0, 32'h5A5A_5A5A, 1, ST_OK, 0, 0);     // tiny segment
    add_row(K_ALLOC, 0, 0, 0, 1, ST_NO_SPACE, 0, 0);
    add_row(K_DETACH, 0, 0, 0, 1, ST_OK, 10, 32'h5A5A_5A5A);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].kind, rows[i].req, rows[i].off, rows[i].base,
                           rows[i].typed, rows[i].exp);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 900) begin
        item.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      req  = 17'($urandom_range(0, 64));
      off  = 16'($urandom);
      base = $urandom;
      if (att_len == 0) begin
        k = (pick < 80) ? K_ATTACH : kind_t'($urandom_range(1, 3));
        if (k == K_ATTACH) begin
          case ($urandom_range(0, 9))
            0: req = '0;
            1: req = 17'($urandom_range(1, 300));
            2: req = 17'($urandom_range(65537, 17'h1FFFF));
            3: req = 17'($urandom);
            default: req = 17'd65536;
          endcase
        end
      end else if (pick < 55) begin
        k = K_ALLOC;
        if ($urandom_range(0, 9) == 0) req = 17'($urandom);
      end else if (pick < 91) begin
        k = K_FREE;
        if (ac_cnt != 0 && $urandom_range(0, 6) != 0)
          off = 16'(ac_off[$urandom_range(0, ac_cnt - 1)]);
      end else if (pick < 95) begin
        k = K_ATTACH;
        req = 17'($urandom);
      end else begin
        k = K_DETACH;
      end
      send(k, req, off, base, 1'b0, none);
    end
    item.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: check each transaction, random back-pressure
  initial begin
    seg_result_t e;
    int          stall_left;
    int          hold_left;
    stall_left = 0;
    hold_left  = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction, status %0d",
                                         result.status);
        end else begin
          e = pending_results.pop_front();
          if (result.status !== e.status || result.granted_offset !== e.granted ||
              result.detached_length !== e.dlen || result.detached_base !== e.dbase) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp st=%0d off=%h len=%h base=%h, got st=%0d off=%h len=%h base=%h",
                       results_seen, e.status, e.granted, e.dlen, e.dbase, result.status,
                       result.granted_offset, result.detached_length, result.detached_base);
          end
        end
        if (results_seen == 400) hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
